// File: rtl/core/crc16c_pkg.sv
// Package for the CRC-16/CCITT byte remainder block.
// Holds the generator constant and the byte-wide remainder update function.
// No dependencies.
package crc16c_pkg;

    // Generator 0x11021 aligned to the top of a 32-bit window.
    localparam logic [31:0] CCITT_WINDOW_GEN = 32'h8810_8000;
    // Low 16 bits of 0x11021; the x^16 term is implied by the shift-out.
    localparam logic [15:0] CCITT_POLY = 16'(CCITT_WINDOW_GEN >> 15);

    // Shifts eight message bits, MSB first, into the remainder and reduces
    // modulo the CCITT polynomial, one bit per step.
    function automatic logic [15:0] crc_shift8(input logic [15:0] rem,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        logic        fb;
        crc = rem;
        for (int k = 7; k >= 0; k--) begin
            fb  = crc[15];
            crc = {crc[14:0], data[k]} ^ (fb ? CCITT_POLY : 16'h0000);
        end
        return crc;
    endfunction

endpackage

// File: rtl/core/crc16c_step.sv
// Combinational remainder update for one item of the CRC-16/CCITT block.
// Absorbs a byte when present and forms the final value on the last item.
// Depends on crc16c_pkg.
module crc16c_step (
    input  logic [15:0] i_remainder,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output logic [15:0] o_next_remainder,
    output logic [15:0] o_crc_value
);

    logic [15:0] w_absorbed;

    always_comb begin
        w_absorbed  = i_has_byte ? crc16c_pkg::crc_shift8(i_remainder, i_data_byte)
                                 : i_remainder;
        // The final value appends one zero byte to the message.
        o_crc_value = crc16c_pkg::crc_shift8(w_absorbed, 8'h00);
        // A finished message leaves the remainder clear for the next one.
        o_next_remainder = i_last_byte ? 16'h0000 : w_absorbed;
    end

endmodule

// File: rtl/core/crc16c_out_reg.sv
// Output holding register of the CRC-16/CCITT block.
// Keeps one result until the receiver takes it. No package dependency.
module crc16c_out_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [15:0] i_crc_value,
    output logic        o_free,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_crc_value
);

    logic        r_valid;
    logic        n_valid;
    logic [15:0] r_crc;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_crc_value = r_crc;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_crc <= i_crc_value;
        end
    end

endmodule

// File: rtl/core/crc16_ccitt_byte_remainder.sv
// Top level of the CRC-16/CCITT byte-serial remainder block.
// Instantiates crc16c_step and crc16c_out_reg; depends on crc16c_pkg.
//
// Usage: a message enters one item per handshake on the input channel
// (i_in_valid / o_in_ready), carrying i_data_byte, i_has_byte and
// i_last_byte. Bytes are taken most significant bit first, starting from a
// zero remainder. An item with i_has_byte low adds nothing to the message;
// when it also has i_last_byte low it produces nothing at all.
// The item with i_last_byte high ends the message and yields one result
// on the output channel (o_out_valid / i_out_ready): o_crc_value is the
// message times x^8 reduced modulo x^16+x^12+x^5+1. An empty message gives 0.
//
// Timing: an accepted item is held in the input register while the byte
// update runs on it; a final item's result is then registered into the output
// register, from which it is shown and taken. One item is taken every cycle
// unless a final item waits in the input register for the output register
// to free.
// Reset clears the remainder and the valid flags of the input and output registers.
// When the receiver stalls, the result holds in the output register; later
// non-final items keep flowing, and a second final item waits in the input
// register, which then drops o_in_ready until the output register frees.
module crc16_ccitt_byte_remainder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_crc_value
);

    // Input register holding one accepted item.
    logic        r_in_valid;
    logic        n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_has;
    logic        r_in_last;

    // Running remainder of the current message.
    logic [15:0] r_remainder;

    logic [15:0] w_next_remainder;
    logic [15:0] w_crc_value;
    logic        w_out_free;
    logic        w_adv;
    logic        w_load;
    logic        w_accept;

    // The held item moves on unless it carries a result that cannot be
    // placed in the output register this cycle.
    assign w_adv      = r_in_valid && (!r_in_last || w_out_free);
    assign w_load     = w_adv && r_in_last;
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    crc16c_step u_step (
        .i_remainder      (r_remainder),
        .i_data_byte      (r_in_byte),
        .i_has_byte       (r_in_has),
        .i_last_byte      (r_in_last),
        .o_next_remainder (w_next_remainder),
        .o_crc_value      (w_crc_value)
    );

    crc16c_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_crc_value (w_crc_value),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_crc_value (o_crc_value)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_remainder <= 16'h0000;
        end else begin
            r_in_valid <= n_in_valid;
            if (w_adv) begin
                r_remainder <= w_next_remainder;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_data_byte;
            r_in_has  <= i_has_byte;
            r_in_last <= i_last_byte;
        end
    end

    // A final item never moves while the output register is still occupied.
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && !w_out_free) |-> !o_in_ready)
        else $error("final item advanced into an occupied output register");

    // Finishing a message clears the remainder.
    a_rem_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_remainder == 16'h0000))
        else $error("remainder not cleared after a final item");

    // An item without a byte that does not end the message leaves the remainder.
    a_idle_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_has && !r_in_last) |=> $stable(r_remainder))
        else $error("idle item changed the remainder");

    // A loaded result is shown in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_valid && (o_crc_value == $past(w_crc_value))))
        else $error("loaded result not presented");

endmodule
